>>> rtl/page_map_space_finder_macros.svh
// Assertion macros shared by the page map space finder RTL.
`ifndef PAGE_MAP_SPACE_FINDER_MACROS_SVH
`define PAGE_MAP_SPACE_FINDER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PMSF_ASSERT_IMPLY(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PMSF_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> rtl/pmsf_pkg.sv
// Package with types, constants and helpers of the page map space finder.
package pmsf_pkg;

   // Default sizes in pages.
   localparam int unsigned DEF_SCREEN_PAGES       = 4;
   localparam int unsigned DEF_CHARSET_PAGES      = 8;
   localparam int unsigned DEF_FULL_DRIVER_PAGES  = 4;
   localparam int unsigned DEF_SMALL_DRIVER_PAGES = 2;

   // Fixed blocked ranges of the derived map.
   localparam logic [7:0] FIX_LOW_HI  = 8'h03;
   localparam logic [7:0] FIX_MID_LO  = 8'hA0;
   localparam logic [7:0] FIX_MID_HI  = 8'hBF;
   localparam logic [7:0] FIX_HIGH_LO = 8'hD0;

   // Special start page values.
   localparam logic [7:0] START_DERIVE = 8'h00;
   localparam logic [7:0] START_NONE   = 8'hFF;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCREEN,
      ST_CHARSET,
      ST_DRIVER,
      ST_REPLY
   } pmsf_state_type;

   // Description of the used page map, held instead of the map itself.
   typedef struct packed {
      logic       derive;
      logic       load_valid;
      logic [7:0] load_lo;
      logic [7:0] load_hi;
      logic [7:0] win_lo;
      logic [8:0] win_end;
   } pmsf_map_type;

   // Screen banks are tried in the order 0x00, 0x80, 0x40, 0xC0.
   function automatic logic [7:0] pmsf_bank_base(input logic [1:0] idx);
      logic [7:0] base;
      unique case (idx)
         2'd0: base = 8'h00;
         2'd1: base = 8'h80;
         2'd2: base = 8'h40;
         default: base = 8'hC0;
      endcase
      return base;
   endfunction

endpackage

>>> rtl/pmsf_page_eval.sv
// Shared page evaluator: tells whether one page is blocked in the current map.
module pmsf_page_eval (
   input  pmsf_pkg::pmsf_map_type map_info,
   input  logic [7:0]             page,
   output logic                   blocked
);
   import pmsf_pkg::*;

   logic fixed_hit;
   logic load_hit;
   logic win_hit;

   // Fixed ranges and the load area of the derived map.
   assign fixed_hit = (page <= FIX_LOW_HI) ||
                      ((page >= FIX_MID_LO) && (page <= FIX_MID_HI)) ||
                      (page >= FIX_HIGH_LO);
   assign load_hit  = map_info.load_valid &&
                      (page >= map_info.load_lo) && (page <= map_info.load_hi);

   // Free window of an explicit request.
   assign win_hit = (page >= map_info.win_lo) && ({1'b0, page} < map_info.win_end);

   always_comb begin
      if (map_info.derive) begin
         blocked = fixed_hit || load_hit;
      end else begin
         blocked = !win_hit;
      end
   end

endmodule

>>> rtl/page_map_space_finder.sv
// Top level of the page map space finder: request latch, search sequencer, result.
//
//   Channel   Ports                                          Transfer
//   request   start, busy, req_start_page, req_page_count,   start high while busy low
//             req_load_address, req_data_length
//   result    rsp_valid, rsp_driver_page, rsp_screen_page,   rsp_valid high for one cycle
//             rsp_charset_page
//
// A request passes through a setup step, a check of each page or a skip of each slot
// for a screen or charset, driver scans and a result step. The page evaluator checks
// one page per cycle.
// Busy stays high from acceptance through the result cycle; one request at a time.
// The page map is not stored, so reset needs no clearing pass.
// The result strobe lasts exactly one cycle; the receiver cannot stall it.
`include "page_map_space_finder_macros.svh"

module page_map_space_finder #(
   parameter int unsigned SCREEN_PAGES       = pmsf_pkg::DEF_SCREEN_PAGES,
   parameter int unsigned CHARSET_PAGES      = pmsf_pkg::DEF_CHARSET_PAGES,
   parameter int unsigned FULL_DRIVER_PAGES  = pmsf_pkg::DEF_FULL_DRIVER_PAGES,
   parameter int unsigned SMALL_DRIVER_PAGES = pmsf_pkg::DEF_SMALL_DRIVER_PAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_start_page,
   input  logic [7:0]  req_page_count,
   input  logic [15:0] req_load_address,
   input  logic [15:0] req_data_length,
   output logic        rsp_valid,
   output logic [7:0]  rsp_driver_page,
   output logic [7:0]  rsp_screen_page,
   output logic [7:0]  rsp_charset_page
);
   import pmsf_pkg::*;

   localparam logic [2:0] SCR_LAST  = 3'(SCREEN_PAGES - 1);
   localparam logic [2:0] CHR_LAST  = 3'(CHARSET_PAGES - 1);
   localparam logic [8:0] SCR_SPAN  = 9'(SCREEN_PAGES);
   localparam logic [8:0] CHR_SPAN  = 9'(CHARSET_PAGES);
   localparam logic [7:0] NEED_FULL = 8'(FULL_DRIVER_PAGES);
   localparam logic [7:0] NEED_SMALL = 8'(SMALL_DRIVER_PAGES);

   pmsf_state_type state_ff, state_in;
   pmsf_map_type   map_ff, map_in;

   logic [7:0]  sp_ff, sp_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [15:0] load_ff, load_in;
   logic [15:0] len_ff, len_in;
   logic [1:0]  bank_ff, bank_in;
   logic [3:0]  slot_ff, slot_in;
   logic [2:0]  chr_ff, chr_in;
   logic [2:0]  off_ff, off_in;
   logic [7:0]  page_ff, page_in;
   logic [7:0]  first_ff, first_in;
   logic        fallback_ff, fallback_in;
   logic [7:0]  drv_ff, drv_in;
   logic [7:0]  scr_ff, scr_in;
   logic [7:0]  chrp_ff, chrp_in;

   logic [7:0]  bank_base;
   logic        chr_bank;
   logic [7:0]  scr_page;
   logic [7:0]  chr_page;
   logic [7:0]  eval_page;
   logic        eval_blocked;
   logic [16:0] load_total;
   logic [16:0] load_last;
   logic [7:0]  load_hi;
   logic [8:0]  win_sum;
   logic        in_scr;
   logic        in_chr;
   logic        drv_blk;
   logic [7:0]  run_len;
   logic [7:0]  need;
   logic        adv_slot;
   logic        adv_chr;

   // Current candidate placement.
   assign bank_base = pmsf_bank_base(bank_ff);
   assign chr_bank  = bank_base[6];
   assign scr_page  = bank_base | {2'b00, slot_ff, 2'b00};
   assign chr_page  = bank_base | {2'b00, chr_ff, 3'b000};

   // Page presented to the shared evaluator.
   always_comb begin
      unique case (state_ff)
         ST_SCREEN:  eval_page = scr_page + {5'd0, off_ff};
         ST_CHARSET: eval_page = chr_page + {5'd0, off_ff};
         default:    eval_page = page_ff;
      endcase
   end

   pmsf_page_eval u_eval (
      .map_info (map_ff),
      .page     (eval_page),
      .blocked  (eval_blocked)
   );

   // Load area and window bounds, computed in the setup cycle.
   assign load_total = {1'b0, load_ff} + {1'b0, len_ff};
   assign load_last  = load_total - 17'd1;
   assign load_hi    = load_last[16] ? 8'hFF : load_last[15:8];
   assign win_sum    = {1'b0, sp_ff} + {1'b0, cnt_ff};

   // Driver scan: screen and charset of the candidate count as blocked.
   assign in_scr  = !fallback_ff && (scr_page != 8'd0) && (page_ff >= scr_page) &&
                    ({1'b0, page_ff} < ({1'b0, scr_page} + SCR_SPAN));
   assign in_chr  = !fallback_ff && chr_bank && (chr_page != 8'd0) &&
                    (page_ff >= chr_page) &&
                    ({1'b0, page_ff} < ({1'b0, chr_page} + CHR_SPAN));
   assign drv_blk = eval_blocked || in_scr || in_chr;
   assign run_len = page_ff - first_ff;
   assign need    = fallback_ff ? NEED_SMALL : NEED_FULL;

   // Sequencer: next state and counters.
   always_comb begin
      state_in    = state_ff;
      map_in      = map_ff;
      sp_in       = sp_ff;
      cnt_in      = cnt_ff;
      load_in     = load_ff;
      len_in      = len_ff;
      bank_in     = bank_ff;
      slot_in     = slot_ff;
      chr_in      = chr_ff;
      off_in      = off_ff;
      page_in     = page_ff;
      first_in    = first_ff;
      fallback_in = fallback_ff;
      drv_in      = drv_ff;
      scr_in      = scr_ff;
      chrp_in     = chrp_ff;
      adv_slot    = 1'b0;
      adv_chr     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sp_in    = req_start_page;
               cnt_in   = req_page_count;
               load_in  = req_load_address;
               len_in   = req_data_length;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            map_in.derive     = (sp_ff == START_DERIVE);
            map_in.load_lo    = load_ff[15:8];
            map_in.load_hi    = load_hi;
            map_in.load_valid = (load_total != 17'd0) && (load_hi >= load_ff[15:8]);
            map_in.win_lo     = sp_ff;
            map_in.win_end    = (win_sum > 9'd256) ? 9'd256 : win_sum;
            drv_in      = 8'd0;
            scr_in      = 8'd0;
            chrp_in     = 8'd0;
            bank_in     = 2'd0;
            slot_in     = 4'd0;
            off_in      = 3'd0;
            fallback_in = 1'b0;
            if (sp_ff == START_NONE) begin
               state_in = ST_REPLY;
            end else begin
               state_in = ST_SCREEN;
            end
         end
         ST_SCREEN: begin
            if (!chr_bank && (slot_ff[3:2] == 2'b01)) begin
               // Character ROM mirror slots are never used for a screen.
               adv_slot = 1'b1;
            end else if (eval_blocked) begin
               adv_slot = 1'b1;
            end else if (off_ff == SCR_LAST) begin
               off_in = 3'd0;
               if (chr_bank) begin
                  chr_in   = 3'd0;
                  state_in = ST_CHARSET;
               end else begin
                  page_in  = 8'd0;
                  first_in = 8'd0;
                  state_in = ST_DRIVER;
               end
            end else begin
               off_in = off_ff + 3'd1;
            end
         end
         ST_CHARSET: begin
            if (chr_ff == slot_ff[3:1]) begin
               // The charset may not share an 8-page group with the screen.
               adv_chr = 1'b1;
            end else if (eval_blocked) begin
               adv_chr = 1'b1;
            end else if (off_ff == CHR_LAST) begin
               off_in   = 3'd0;
               page_in  = 8'd0;
               first_in = 8'd0;
               state_in = ST_DRIVER;
            end else begin
               off_in = off_ff + 3'd1;
            end
         end
         ST_DRIVER: begin
            if (drv_blk && (run_len >= need)) begin
               // First long enough run that ends at a blocked page.
               if (first_ff != 8'd0) begin
                  drv_in = first_ff;
                  if (!fallback_ff) begin
                     scr_in  = scr_page;
                     chrp_in = chr_bank ? chr_page : 8'd0;
                  end
                  state_in = ST_REPLY;
               end else if (fallback_ff) begin
                  state_in = ST_REPLY;
               end else if (chr_bank) begin
                  adv_chr = 1'b1;
               end else begin
                  adv_slot = 1'b1;
               end
            end else if (page_ff == 8'hFF) begin
               if (fallback_ff) begin
                  state_in = ST_REPLY;
               end else if (chr_bank) begin
                  adv_chr = 1'b1;
               end else begin
                  adv_slot = 1'b1;
               end
            end else begin
               if (drv_blk) begin
                  first_in = page_ff + 8'd1;
               end
               page_in = page_ff + 8'd1;
            end
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Next charset slot, or the next screen slot once all are tried.
      if (adv_chr) begin
         if (chr_ff == 3'd7) begin
            adv_slot = 1'b1;
         end else begin
            chr_in   = chr_ff + 3'd1;
            off_in   = 3'd0;
            state_in = ST_CHARSET;
         end
      end

      // Next screen slot, next bank, or the small driver without a screen.
      if (adv_slot) begin
         off_in = 3'd0;
         if (slot_ff == 4'hF) begin
            slot_in = 4'd0;
            if (bank_ff == 2'd3) begin
               fallback_in = 1'b1;
               page_in     = 8'd0;
               first_in    = 8'd0;
               state_in    = ST_DRIVER;
            end else begin
               bank_in  = bank_ff + 2'd1;
               state_in = ST_SCREEN;
            end
         end else begin
            slot_in  = slot_ff + 4'd1;
            state_in = ST_SCREEN;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload and search registers.
   always_ff @(posedge clock) begin
      map_ff      <= map_in;
      sp_ff       <= sp_in;
      cnt_ff      <= cnt_in;
      load_ff     <= load_in;
      len_ff      <= len_in;
      bank_ff     <= bank_in;
      slot_ff     <= slot_in;
      chr_ff      <= chr_in;
      off_ff      <= off_in;
      page_ff     <= page_in;
      first_ff    <= first_in;
      fallback_ff <= fallback_in;
      drv_ff      <= drv_in;
      scr_ff      <= scr_in;
      chrp_ff     <= chrp_in;
   end

   // Ports.
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_REPLY);
   assign rsp_driver_page  = drv_ff;
   assign rsp_screen_page  = scr_ff;
   assign rsp_charset_page = chrp_ff;

   // Checks on the sequencer and the result.
   `PMSF_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `PMSF_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !rsp_valid, "request not held busy")
   `PMSF_ASSERT_IMPLY(a_no_driver_empty, rsp_valid && (rsp_driver_page == 8'd0), (rsp_screen_page == 8'd0) && (rsp_charset_page == 8'd0), "screen or charset without driver")
   `PMSF_ASSERT_IMPLY(a_charset_group, rsp_valid && (rsp_charset_page != 8'd0), (rsp_screen_page != 8'd0) && (rsp_charset_page[7:3] != rsp_screen_page[7:3]), "charset clashes with screen")

endmodule
